/* hdl/hvn_pkg.sv */
package hvn_pkg;

	localparam int HT_W = 8;
	localparam int DIM_W = 11;
	localparam int ROW_W = 10;
	localparam int COORD_W = 10;
	localparam int ROW_LIMIT = 1024;
	localparam int NV_W = 20;
	localparam int MAG_W = 19;
	localparam int MSQ_W = 2 * MAG_W;
	localparam int SUM_W = MSQ_W + 2;
	localparam int RSHIFT = 30;
	localparam int REF_W = MSQ_W + RSHIFT;
	localparam int ACC_W = 76;
	localparam int NBITS = 15;
	localparam int Q_W = 16;
	localparam int VS_W = 18;
	localparam int FACE_Y = 255;

	typedef logic signed [NV_W-1:0] nin_t;
	typedef logic signed [Q_W-1:0] qnorm_t;
	typedef logic signed [VS_W-1:0] vsum_t;

	typedef struct packed {
		logic busy;
		logic done;
	} norm_sts_t;

endpackage

/* hdl/hvn_normalize.sv */
module hvn_normalize import hvn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input nin_t vec [3],
	output norm_sts_t sts,
	output qnorm_t res [3]
);

	typedef enum logic [2:0] {N_IDLE, N_SQ, N_SUM, N_INIT, N_ITER} nstate_t;

	nstate_t state_q;
	logic [1:0] k_q;
	logic [3:0] b_q;
	logic [MAG_W-1:0] mag_q [3];
	logic neg_q [3];
	logic [MSQ_W-1:0] msq_q [3];
	logic [SUM_W-1:0] s_q;
	logic [REF_W-1:0] r_q;
	logic signed [ACC_W-1:0] p_q;
	logic signed [ACC_W-1:0] q_q;
	logic [NBITS-1:0] n_q;
	logic done_q;
	qnorm_t res_q [3];

	logic signed [ACC_W-1:0] s_ext;
	logic signed [ACC_W-1:0] r_ext;
	logic signed [ACC_W-1:0] cand;
	logic [4:0] sh0;
	logic [4:0] sh1;
	logic [4:0] sh2;
	logic take;
	logic [NBITS-1:0] n_next;
	logic signed [NV_W:0] absv [3];

	always_comb begin
		s_ext = $signed({{(ACC_W-SUM_W){1'b0}}, s_q});
		r_ext = $signed({{(ACC_W-REF_W){1'b0}}, r_q});
		sh0 = 5'(b_q) + 5'd1;
		sh1 = 5'(b_q) + 5'd2;
		sh2 = {b_q, 1'b0} + 5'd2;
		cand = p_q + (q_q <<< sh1) + (s_ext <<< sh2);
		take = (cand <= r_ext);
		n_next = take ? (n_q | (NBITS'(1) << b_q)) : n_q;
		for (int c = 0; c < 3; c++) begin
			absv[c] = vec[c][NV_W-1] ? -$signed({vec[c][NV_W-1], vec[c]})
				: $signed({vec[c][NV_W-1], vec[c]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q <= 1'b0;
			k_q <= '0;
			b_q <= '0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						for (int c = 0; c < 3; c++) begin
							mag_q[c] <= absv[c][MAG_W-1:0];
							neg_q[c] <= vec[c][NV_W-1];
						end
						k_q <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					msq_q[k_q] <= mag_q[k_q] * mag_q[k_q];
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= N_SUM;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				N_SUM: begin
					s_q <= SUM_W'(msq_q[0]) + SUM_W'(msq_q[1]) + SUM_W'(msq_q[2]);
					state_q <= N_INIT;
				end
				N_INIT: begin
					r_q <= {msq_q[k_q], {RSHIFT{1'b0}}};
					p_q <= s_ext;
					q_q <= -s_ext;
					n_q <= '0;
					b_q <= 4'(NBITS - 1);
					state_q <= N_ITER;
				end
				N_ITER: begin
					if (take) begin
						p_q <= cand;
						q_q <= q_q + (s_ext <<< sh0);
					end
					n_q <= n_next;
					if (b_q == 4'd0) begin
						res_q[k_q] <= neg_q[k_q] ? -$signed({1'b0, n_next})
							: $signed({1'b0, n_next});
						if (k_q == 2'd2) begin
							done_q <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= N_INIT;
						end
					end else begin
						b_q <= b_q - 4'd1;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != N_IDLE);
	assign sts.done = done_q;
	assign res = res_q;

endmodule

/* hdl/heightmap_vertex_normals_top.sv */
// Smooth vertex normals for a height grid streamed in raster order. A pixel that closes no quad
// (first row or first column) emits no vertex. A pixel that closes a quad emits k vertices
// (k is 1 to 4), writes one more column entry in the last column and waits while the output
// is stalled: two face normalizations and k vertex normalizations run one after another
// through a single normalization unit that takes one vector at a time (three squares, a sum
// and a 15-step root search for each component).
// Column state sits in two memories of MAX_GRID_WIDTH entries that need no clearing after reset.
module heightmap_vertex_normals_top import hvn_pkg::*; #(
	parameter int MAX_GRID_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [DIM_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [HT_W-1:0] height,
	output logic out_valid,
	input logic out_stall,
	output logic [COORD_W-1:0] vertex_row,
	output logic [COORD_W-1:0] vertex_col,
	output logic signed [Q_W-1:0] normal_x,
	output logic signed [Q_W-1:0] normal_y,
	output logic signed [Q_W-1:0] normal_z,
	output logic run_end,
	output logic frame_end
);

	localparam int COL_W = $clog2(MAX_GRID_WIDTH);
	localparam logic REG_WIDTH = 1'b0;
	localparam logic [1:0] VX_UP_LEFT = 2'd0;
	localparam logic [1:0] VX_UP_RIGHT = 2'd1;
	localparam logic [1:0] VX_LO_LEFT = 2'd2;
	localparam logic [1:0] VX_LO_RIGHT = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_F0, S_F1, S_WRA, S_WRB, S_VSTART, S_VWAIT, S_OUT, S_DONE
	} state_t;

	state_t state_q;
	logic [DIM_W-1:0] gw_q;
	logic [DIM_W-1:0] gh_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] cj_q;
	logic [ROW_W-1:0] ci_q;
	logic comp_q;
	logic lc_q;
	logic lr_q;
	logic [HT_W-1:0] hv_q;
	logic [2*HT_W-1:0] left_q;
	logic [1:0] vk_q;
	vsum_t up_left_q [3];
	vsum_t lo_left_q [3];
	qnorm_t n0_q [3];
	qnorm_t n1_q [3];

	logic [HT_W-1:0] prev_mem [MAX_GRID_WIDTH];
	logic [3*VS_W-1:0] up_mem [MAX_GRID_WIDTH];
	logic [HT_W-1:0] prev_rd_q;
	logic [3*VS_W-1:0] up_rd_q;

	logic out_valid_q;
	logic [COORD_W-1:0] row_out_q;
	logic [COORD_W-1:0] col_out_q;
	qnorm_t nrm_out_q [3];
	logic run_end_q;
	logic frame_end_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] wm1;
	logic [DIM_W-1:0] hm1;
	logic restart;
	logic [COL_W-1:0] j_acc;
	logic [ROW_W-1:0] i_acc;
	logic accept;
	logic out_free;
	logic [COL_W:0] j_inc;
	logic [ROW_W:0] i_inc;

	logic [HT_W-1:0] h00;
	logic [HT_W-1:0] h10;
	logic signed [HT_W:0] d_a;
	logic signed [HT_W:0] d_b;
	logic signed [HT_W:0] d_c;
	logic signed [HT_W:0] d_d;
	logic signed [NV_W:0] p_a;
	logic signed [NV_W:0] p_b;
	logic signed [NV_W:0] p_c;
	logic signed [NV_W:0] p_d;
	nin_t f0 [3];
	nin_t f1 [3];
	vsum_t upr [3];
	vsum_t v0 [3];
	vsum_t v1 [3];
	vsum_t v2 [3];
	vsum_t v3 [3];
	vsum_t vsel [3];
	nin_t nvec [3];
	logic nstart;
	norm_sts_t nsts;
	qnorm_t nres [3];
	logic has_next;
	logic [1:0] vk_next;

	hvn_normalize u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(nstart),
		.vec(nvec),
		.sts(nsts),
		.res(nres)
	);

	always_comb begin
		if (gw_q < DIM_W'(2)) begin
			w_eff = DIM_W'(2);
		end else if (32'(gw_q) > MAX_GRID_WIDTH) begin
			w_eff = DIM_W'(MAX_GRID_WIDTH);
		end else begin
			w_eff = gw_q;
		end
		if (gh_q < DIM_W'(2)) begin
			h_eff = DIM_W'(2);
		end else if (32'(gh_q) > ROW_LIMIT) begin
			h_eff = DIM_W'(ROW_LIMIT);
		end else begin
			h_eff = gh_q;
		end
		wm1 = w_eff - DIM_W'(1);
		hm1 = h_eff - DIM_W'(1);
		restart = (32'(col_q) >= 32'(w_eff)) || (32'(row_q) >= 32'(h_eff));
		j_acc = restart ? '0 : col_q;
		i_acc = restart ? '0 : row_q;
		accept = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		j_inc = {1'b0, cj_q} + (COL_W+1)'(1);
		i_inc = {1'b0, ci_q} + (ROW_W+1)'(1);
	end

	always_comb begin
		h00 = left_q[2*HT_W-1:HT_W];
		h10 = left_q[HT_W-1:0];
		d_a = $signed({1'b0, h10}) - $signed({1'b0, hv_q});
		d_b = $signed({1'b0, h00}) - $signed({1'b0, h10});
		d_c = $signed({1'b0, h00}) - $signed({1'b0, prev_rd_q});
		d_d = $signed({1'b0, prev_rd_q}) - $signed({1'b0, hv_q});
		p_a = $signed({1'b0, wm1}) * d_a;
		p_b = $signed({1'b0, hm1}) * d_b;
		p_c = $signed({1'b0, wm1}) * d_c;
		p_d = $signed({1'b0, hm1}) * d_d;
		f0[0] = NV_W'(p_a);
		f0[1] = NV_W'(FACE_Y);
		f0[2] = NV_W'(p_b);
		f1[0] = NV_W'(p_c);
		f1[1] = NV_W'(FACE_Y);
		f1[2] = NV_W'(p_d);
		for (int c = 0; c < 3; c++) begin
			upr[c] = (ci_q == ROW_W'(1)) ? '0 : $signed(up_rd_q[c*VS_W +: VS_W]);
			v0[c] = up_left_q[c] + VS_W'(n0_q[c]) + VS_W'(n1_q[c]);
			v1[c] = upr[c] + VS_W'(n1_q[c]);
			v2[c] = lo_left_q[c] + VS_W'(n0_q[c]);
			v3[c] = VS_W'(n0_q[c]) + VS_W'(n1_q[c]);
		end
		unique case (vk_q)
			VX_UP_LEFT: vsel = v0;
			VX_UP_RIGHT: vsel = v1;
			VX_LO_LEFT: vsel = v2;
			default: vsel = v3;
		endcase
		for (int c = 0; c < 3; c++) begin
			unique case (state_q)
				S_READ: nvec[c] = f0[c];
				S_F0: nvec[c] = f1[c];
				default: nvec[c] = NV_W'(vsel[c]);
			endcase
		end
		nstart = (state_q == S_READ && comp_q) || (state_q == S_F0 && nsts.done)
			|| (state_q == S_VSTART);
		unique case (vk_q)
			VX_UP_LEFT: begin
				has_next = lc_q || lr_q;
				vk_next = lc_q ? VX_UP_RIGHT : VX_LO_LEFT;
			end
			VX_UP_RIGHT: begin
				has_next = lr_q;
				vk_next = VX_LO_LEFT;
			end
			VX_LO_LEFT: begin
				has_next = lc_q;
				vk_next = VX_LO_RIGHT;
			end
			default: begin
				has_next = 1'b0;
				vk_next = VX_LO_RIGHT;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_rd_q <= prev_mem[j_acc];
			up_rd_q <= up_mem[j_acc];
		end
		if (state_q == S_READ) begin
			prev_mem[cj_q] <= hv_q;
		end
		if (state_q == S_WRA) begin
			up_mem[cj_q - COL_W'(1)] <= {v2[2], v2[1], v2[0]};
		end
		if (state_q == S_WRB) begin
			up_mem[cj_q] <= {v3[2], v3[1], v3[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gw_q <= DIM_W'(2);
			gh_q <= DIM_W'(2);
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			out_valid_q <= 1'b0;
			vk_q <= VX_UP_LEFT;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hv_q <= height;
						cj_q <= j_acc;
						ci_q <= i_acc;
						comp_q <= (i_acc != '0) && (j_acc != '0);
						lc_q <= (32'(j_acc) == 32'(wm1));
						lr_q <= (32'(i_acc) == 32'(hm1));
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= comp_q ? S_F0 : S_DONE;
				end
				S_F0: begin
					if (nsts.done) begin
						n0_q <= nres;
						state_q <= S_F1;
					end
				end
				S_F1: begin
					if (nsts.done) begin
						n1_q <= nres;
						state_q <= S_WRA;
					end
				end
				S_WRA: begin
					vk_q <= VX_UP_LEFT;
					state_q <= lc_q ? S_WRB : S_VSTART;
				end
				S_WRB: begin
					state_q <= S_VSTART;
				end
				S_VSTART: begin
					state_q <= S_VWAIT;
				end
				S_VWAIT: begin
					if (nsts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						row_out_q <= (vk_q == VX_UP_LEFT || vk_q == VX_UP_RIGHT)
							? COORD_W'(ci_q - ROW_W'(1)) : COORD_W'(ci_q);
						col_out_q <= (vk_q == VX_UP_LEFT || vk_q == VX_LO_LEFT)
							? COORD_W'(cj_q - COL_W'(1)) : COORD_W'(cj_q);
						nrm_out_q <= nres;
						run_end_q <= !has_next;
						frame_end_q <= (vk_q == VX_LO_RIGHT);
						vk_q <= vk_next;
						state_q <= has_next ? S_VSTART : S_DONE;
					end
				end
				S_DONE: begin
					left_q <= {prev_rd_q, hv_q};
					if (comp_q) begin
						up_left_q <= v1;
						lo_left_q <= v3;
					end else if (cj_q == '0) begin
						for (int c = 0; c < 3; c++) begin
							up_left_q[c] <= (ci_q <= ROW_W'(1)) ? '0
								: $signed(up_rd_q[c*VS_W +: VS_W]);
							lo_left_q[c] <= '0;
						end
					end
					if (!cfg_we) begin
						if (32'(j_inc) == 32'(w_eff)) begin
							col_q <= '0;
							row_q <= (32'(i_inc) == 32'(h_eff)) ? '0 : ROW_W'(i_inc);
						end else begin
							col_q <= COL_W'(j_inc);
							row_q <= ci_q;
						end
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					gw_q <= cfg_data;
				end else begin
					gh_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign vertex_row = row_out_q;
	assign vertex_col = col_out_q;
	assign normal_x = nrm_out_q[0];
	assign normal_y = nrm_out_q[1];
	assign normal_z = nrm_out_q[2];
	assign run_end = run_end_q;
	assign frame_end = frame_end_q;

	assert property (@(posedge clk) disable iff (!arst_n) nstart |-> !nsts.busy)
		else $error("Normalizer started while busy.");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (!frame_end || run_end))
		else $error("Frame end without run end.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VSTART && vk_q == VX_LO_RIGHT) |-> (lc_q && lr_q))
		else $error("Corner vertex outside the last row and column.");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> (normal_y > 0))
		else $error("Normal y component not positive.");

endmodule
